### sv/rpi_pkg.sv
// Shared types and constants for the radar peak interpolation core.
// No dependencies; used by rpi_prep and the top level.
package rpi_pkg;

    localparam int unsigned MAX_RANGE_BINS   = 4096;
    localparam int unsigned MAX_DOPPLER_BINS = 4096;

    localparam int MAG_W = 31;
    localparam int BIN_W = 12;
    localparam int CNT_W = 13;
    localparam int RES_W = 31;

    // configuration register indexes
    localparam logic [1:0] REG_RANGE_RES   = 2'd0;
    localparam logic [1:0] REG_VEL_RES     = 2'd1;
    localparam logic [1:0] REG_RANGE_CNT   = 2'd2;
    localparam logic [1:0] REG_DOPPLER_CNT = 2'd3;

    localparam logic [16:0] Q16_ONE      = 17'h10000;
    localparam logic [32:0] Q16_ONE_HALF = 33'd98304;
    localparam logic [31:0] W_NUM        = 32'h8000_0000;
    localparam logic [30:0] SAT31        = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [BIN_W-1:0]   range_bin;
        logic [BIN_W-1:0]   doppler_bin;
        logic [MAG_W-1:0]   mag_below;
        logic [MAG_W-1:0]   mag_center;
        logic [MAG_W-1:0]   mag_above;
        logic signed [31:0] amplitude_in;
        logic signed [31:0] snr_in;
        logic               last_in;
    } det_t;

    typedef struct packed {
        logic [30:0]        distance;
        logic signed [31:0] velocity;
        logic signed [31:0] amplitude_out;
        logic signed [31:0] snr_out;
        logic               distance_overflow;
        logic               velocity_overflow;
        logic               last_out;
    } res_t;

    // first stage result: ordered magnitudes and branch flags
    typedef struct packed {
        logic               peak;
        logic               lt2;
        logic               wzero;
        logic               neg;
        logic [MAG_W-1:0]   top_mag;
        logic [MAG_W-1:0]   mid_mag;
        logic [MAG_W-1:0]   low_mag;
        logic [BIN_W-1:0]   rbin;
        logic signed [13:0] sbin;
        logic signed [31:0] amp;
        logic signed [31:0] snr;
        logic               last;
    } prep_t;

endpackage

### sv/rpi_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband payload.
// Standalone; expects num >> QUO_W to be below den.
module rpi_div_pipe #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32,
    parameter int QUO_W = 17,
    parameter int PAY_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [PAY_W-1:0] pay_in,
    output logic             out_valid,
    output logic [QUO_W-1:0] quo,
    output logic [PAY_W-1:0] pay_out
);

    logic             valid_reg [QUO_W];
    logic [DEN_W-1:0] rem_reg   [QUO_W];
    logic [DEN_W-1:0] den_reg   [QUO_W];
    logic [QUO_W-1:0] low_reg   [QUO_W];
    logic [QUO_W-1:0] quo_reg   [QUO_W];
    logic [PAY_W-1:0] pay_reg   [QUO_W];

    genvar k;
    for (k = 0; k < QUO_W; k++)
    begin : g_stage
        logic             v_src;
        logic [DEN_W-1:0] rem_src;
        logic [DEN_W-1:0] den_src;
        logic [QUO_W-1:0] low_src;
        logic [QUO_W-1:0] quo_src;
        logic [PAY_W-1:0] pay_src;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign v_src   = in_valid;
            assign rem_src = DEN_W'(num >> QUO_W);
            assign den_src = den;
            assign low_src = num[QUO_W-1:0];
            assign quo_src = '0;
            assign pay_src = pay_in;
        end
        else
        begin : g_next
            assign v_src   = valid_reg[k-1];
            assign rem_src = rem_reg[k-1];
            assign den_src = den_reg[k-1];
            assign low_src = low_reg[k-1];
            assign quo_src = quo_reg[k-1];
            assign pay_src = pay_reg[k-1];
        end

        assign trial = {rem_src, low_src[QUO_W-1]};
        assign diff  = trial - {1'b0, den_src};
        assign ge    = (trial >= {1'b0, den_src});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                den_reg[k] <= den_src;
                low_reg[k] <= low_src << 1;
                quo_reg[k] <= {quo_src[QUO_W-2:0], ge};
                pay_reg[k] <= pay_src;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign quo       = quo_reg[QUO_W-1];
    assign pay_out   = pay_reg[QUO_W-1];

endmodule

### sv/rpi_prep.sv
// Input stage: range edge zeroing, peak test, neighbor ordering, Doppler sign.
// Depends on rpi_pkg.
module rpi_prep (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      det_valid,
    input  rpi_pkg::det_t             det,
    input  logic [rpi_pkg::CNT_W-1:0] range_bin_count,
    input  logic [rpi_pkg::CNT_W-1:0] doppler_bin_count,
    output logic                      prep_valid,
    output rpi_pkg::prep_t            prep
);

    logic                      valid_reg;
    rpi_pkg::prep_t            prep_reg;
    rpi_pkg::prep_t            prep_next;
    logic [rpi_pkg::MAG_W-1:0] lo;
    logic [rpi_pkg::MAG_W-1:0] hi;
    logic [rpi_pkg::CNT_W-1:0] rbin_up;

    assign rbin_up = {1'b0, det.range_bin} + rpi_pkg::CNT_W'(1);

    always_comb
    begin
        lo = (det.range_bin == '0) ? '0 : det.mag_below;
        hi = (rbin_up < range_bin_count) ? det.mag_above : '0;

        prep_next.peak    = !(lo > det.mag_center) && !(hi > det.mag_center)
                            && (det.mag_center != '0);
        prep_next.top_mag = det.mag_center;
        if (lo > hi)
        begin
            prep_next.mid_mag = lo;
            prep_next.low_mag = hi;
            prep_next.neg     = 1'b1;
        end
        else
        begin
            prep_next.mid_mag = hi;
            prep_next.low_mag = lo;
            prep_next.neg     = 1'b0;
        end
        // ratio below 2.0 means center < 2 * smaller neighbor
        prep_next.lt2   = {1'b0, det.mag_center} < {prep_next.low_mag, 1'b0};
        // ratio at or above 2^17 (or zero neighbor): the weight comes out zero
        prep_next.wzero = {17'b0, det.mag_center[30:17]} >= prep_next.low_mag;

        if (det.doppler_bin >= doppler_bin_count[12:1])
        begin
            prep_next.sbin = $signed({2'b00, det.doppler_bin})
                           - $signed({1'b0, doppler_bin_count});
        end
        else
        begin
            prep_next.sbin = $signed({2'b00, det.doppler_bin});
        end
        prep_next.rbin = det.range_bin;
        prep_next.amp  = det.amplitude_in;
        prep_next.snr  = det.snr_in;
        prep_next.last = det.last_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= det_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg <= prep_next;
        end
    end

    assign prep_valid = valid_reg;
    assign prep       = prep_reg;

endmodule

### sv/radar_peak_interp_range_velocity_core.sv
// Top level of the radar peak interpolation core: range/velocity from one detection.
// Depends on rpi_pkg, rpi_prep and rpi_div_pipe.
//
// Usage:
//   Detections enter on det (det_valid/det_stall); each gives exactly one item
//   on res (res_valid/res_stall). An item is taken when valid is high and
//   stall is low. Configuration is written through cfg_we/cfg_index/cfg_data
//   while the block is empty.
// Path: from acceptance to res_valid, one input stage, a 33-stage ratio
//   divider, the weight divisor register, a 17-stage weight divider, the
//   fraction product register, two parallel 17-stage fraction dividers, and
//   the index, distance multiply and output registers.
// Throughput: one item per cycle while det_stall is low; every divider is fully pipelined.
// Stall: while an item waits at the output, the pipeline keeps moving and
//   fills any bubbles; it freezes (det_stall high) only when its last stage
//   also holds an item. Nothing is dropped or repeated.
// Reset: all valid bits clear; resolutions read zero and both bin counts
//   read 4096.
module radar_peak_interp_range_velocity_core #(
    parameter int unsigned MAX_RANGE_BINS   = rpi_pkg::MAX_RANGE_BINS,
    parameter int unsigned MAX_DOPPLER_BINS = rpi_pkg::MAX_DOPPLER_BINS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [30:0]   cfg_data,
    input  logic          det_valid,
    output logic          det_stall,
    input  rpi_pkg::det_t det,
    output logic          res_valid,
    input  logic          res_stall,
    output rpi_pkg::res_t res
);

    typedef struct packed {
        rpi_pkg::prep_t     p;
        logic signed [45:0] vprod;
    } s2_t;

    typedef struct packed {
        logic                      peak;
        logic [rpi_pkg::BIN_W-1:0] rbin;
        logic signed [31:0]        vel;
        logic                      vovf;
        logic signed [31:0]        amp;
        logic signed [31:0]        snr;
        logic                      last;
    } s3_t;

    localparam logic signed [45:0] VP_MAX = 46'sd2147483647;
    localparam logic signed [45:0] VP_MIN = -46'sd2147483647;

    // configuration
    logic [rpi_pkg::RES_W-1:0] range_res_reg;
    logic [rpi_pkg::RES_W-1:0] vel_res_reg;
    logic [rpi_pkg::CNT_W-1:0] range_cnt_reg;
    logic [rpi_pkg::CNT_W-1:0] doppler_cnt_reg;

    logic en;
    logic pipe_hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_res_reg   <= '0;
            vel_res_reg     <= '0;
            range_cnt_reg   <= rpi_pkg::CNT_W'(MAX_RANGE_BINS);
            doppler_cnt_reg <= rpi_pkg::CNT_W'(MAX_DOPPLER_BINS);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rpi_pkg::REG_RANGE_RES:   range_res_reg   <= cfg_data;
                rpi_pkg::REG_VEL_RES:     vel_res_reg     <= cfg_data;
                rpi_pkg::REG_RANGE_CNT:   range_cnt_reg   <= cfg_data[rpi_pkg::CNT_W-1:0];
                rpi_pkg::REG_DOPPLER_CNT: doppler_cnt_reg <= cfg_data[rpi_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1
    logic           prep_valid;
    rpi_pkg::prep_t prep;

    rpi_prep u_prep (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (en),
        .det_valid         (det_valid),
        .det               (det),
        .range_bin_count   (range_cnt_reg),
        .doppler_bin_count (doppler_cnt_reg),
        .prep_valid        (prep_valid),
        .prep              (prep)
    );

    // ratio = center * 2^16 / smaller neighbor
    logic           ra_valid;
    logic [32:0]    ratio;
    rpi_pkg::prep_t ra_prep;

    rpi_div_pipe #(
        .NUM_W (47),
        .DEN_W (31),
        .QUO_W (33),
        .PAY_W ($bits(rpi_pkg::prep_t))
    ) u_div_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .num       ({prep.top_mag, 16'b0}),
        .den       (prep.low_mag),
        .pay_in    (prep),
        .out_valid (ra_valid),
        .quo       (ratio),
        .pay_out   (ra_prep)
    );

    // stage 2: weight divisor and velocity product
    logic        s2_valid_reg;
    logic [33:0] wden_reg;
    s2_t         s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= ra_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ra_prep.lt2 || ra_prep.wzero)
            begin
                wden_reg <= '1;
            end
            else
            begin
                wden_reg <= {1'b0, ratio - rpi_pkg::Q16_ONE_HALF};
            end
            s2_reg.p     <= ra_prep;
            s2_reg.vprod <= 46'(ra_prep.sbin) * 46'($signed({1'b0, vel_res_reg}));
        end
    end

    // w = 2^31 / (ratio - 1.5)
    logic        wd_valid;
    logic [16:0] wq;
    s2_t         wd_s2;

    rpi_div_pipe #(
        .NUM_W (32),
        .DEN_W (34),
        .QUO_W (17),
        .PAY_W ($bits(s2_t))
    ) u_div_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .num       (rpi_pkg::W_NUM),
        .den       (wden_reg),
        .pay_in    (s2_reg),
        .out_valid (wd_valid),
        .quo       (wq),
        .pay_out   (wd_s2)
    );

    // stage 3: products for the two fraction terms, velocity saturation
    logic        s3_valid_reg;
    logic [47:0] p1_reg;
    logic [47:0] p2_reg;
    logic [31:0] den1_reg;
    logic [31:0] den2_reg;
    logic        neg3_reg;
    s3_t         s3_reg;
    logic [16:0] w_eff;

    always_comb
    begin
        if (wd_s2.p.lt2)
        begin
            w_eff = rpi_pkg::Q16_ONE;
        end
        else if (wd_s2.p.wzero)
        begin
            w_eff = '0;
        end
        else
        begin
            w_eff = wq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= wd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // with ratio below two, the first term vanishes and w is one
            p1_reg   <= 48'(rpi_pkg::Q16_ONE - w_eff) * 48'(wd_s2.p.low_mag);
            p2_reg   <= 48'(w_eff) * 48'(wd_s2.p.mid_mag);
            den1_reg <= wd_s2.p.lt2 ? {1'b0, wd_s2.p.top_mag}
                                    : {1'b0, wd_s2.p.top_mag - wd_s2.p.low_mag};
            den2_reg <= {1'b0, wd_s2.p.top_mag} + {1'b0, wd_s2.p.mid_mag};
            neg3_reg <= wd_s2.p.neg;
            s3_reg.peak <= wd_s2.p.peak;
            s3_reg.rbin <= wd_s2.p.rbin;
            s3_reg.amp  <= wd_s2.p.amp;
            s3_reg.snr  <= wd_s2.p.snr;
            s3_reg.last <= wd_s2.p.last;
            if (wd_s2.vprod > VP_MAX)
            begin
                s3_reg.vel  <= 32'sh7FFF_FFFF;
                s3_reg.vovf <= 1'b1;
            end
            else if (wd_s2.vprod < VP_MIN)
            begin
                s3_reg.vel  <= 32'sh8000_0001;
                s3_reg.vovf <= 1'b1;
            end
            else
            begin
                s3_reg.vel  <= wd_s2.vprod[31:0];
                s3_reg.vovf <= 1'b0;
            end
        end
    end

    // fraction terms
    logic        f1_valid;
    logic [16:0] q1;
    s3_t         f1_s3;
    logic        f2_valid;
    logic [16:0] q2;
    logic        f2_neg;

    rpi_div_pipe #(
        .NUM_W (48),
        .DEN_W (32),
        .QUO_W (17),
        .PAY_W ($bits(s3_t))
    ) u_div_term1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .num       (p1_reg),
        .den       (den1_reg),
        .pay_in    (s3_reg),
        .out_valid (f1_valid),
        .quo       (q1),
        .pay_out   (f1_s3)
    );

    rpi_div_pipe #(
        .NUM_W (48),
        .DEN_W (32),
        .QUO_W (17),
        .PAY_W (1)
    ) u_div_term2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .num       (p2_reg),
        .den       (den2_reg),
        .pay_in    (neg3_reg),
        .out_valid (f2_valid),
        .quo       (q2),
        .pay_out   (f2_neg)
    );

    // stage 4: refined Q16 index
    logic        s4_valid_reg;
    logic [28:0] idx_reg;
    s3_t         s4_reg;
    logic [17:0] frac;
    logic [28:0] center;

    assign frac   = f1_s3.peak ? ({1'b0, q1} + {1'b0, q2}) : '0;
    assign center = {1'b0, f1_s3.rbin, 16'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= f1_valid && f2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx_reg <= f2_neg ? (center - {11'b0, frac}) : (center + {11'b0, frac});
            s4_reg  <= f1_s3;
        end
    end

    // stage 5: distance product
    logic        s5_valid_reg;
    logic [59:0] dprod_reg;
    s3_t         s5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dprod_reg <= 60'(idx_reg) * 60'(range_res_reg);
            s5_reg    <= s4_reg;
        end
    end

    // output register
    logic          res_valid_reg;
    rpi_pkg::res_t res_reg;
    rpi_pkg::res_t res_next;
    logic [43:0]   dist_full;
    logic          out_busy;

    assign dist_full = dprod_reg[59:16];
    assign out_busy  = res_valid_reg && res_stall;
    assign pipe_hold = s5_valid_reg && out_busy;
    assign en        = !pipe_hold;
    assign det_stall = pipe_hold;

    always_comb
    begin
        res_next.distance_overflow = |dist_full[43:31];
        res_next.distance          = res_next.distance_overflow ? rpi_pkg::SAT31
                                                                : dist_full[30:0];
        res_next.velocity          = s5_reg.vel;
        res_next.velocity_overflow = s5_reg.vovf;
        res_next.amplitude_out     = s5_reg.amp;
        res_next.snr_out           = s5_reg.snr;
        res_next.last_out          = s5_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (!out_busy)
        begin
            res_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_busy)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
